// ===== sv/ordered_point_list_engine_top_macros.svh =====
// Assertion helpers shared by the list engine modules.
`ifndef ORDERED_POINT_LIST_ENGINE_TOP_MACROS_SVH
`define ORDERED_POINT_LIST_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define OPL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define OPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/opl_pkg.sv =====
package opl_pkg;

    // List geometry
    localparam int CAPACITY = 64;
    localparam int PT_W     = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Match scan works on groups of cells, one group per cycle
    localparam int GRP      = 8;
    localparam int GRP_IW   = $clog2(GRP);
    localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;
    localparam int GRP_W    = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int POS_W    = GRP_W + GRP_IW;

    // Result field widths
    localparam int MPOS_W   = 6;
    localparam int OCNT_W   = 7;

    // Request codes
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_DELETE     = 3'd4;
    localparam logic [2:0] REQ_SEARCH     = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_LEFT,
        CELL_RIGHT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     valid;
    } t_cell_ctl;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [POS_W-1:0] pos;
    } t_scan_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_SCAN,
        S_APPLY,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic [7:0]        x;
        logic [7:0]        y;
        logic              found;
        logic [MPOS_W-1:0] pos;
        logic [OCNT_W-1:0] count;
        logic [1:0]        status;
    } t_result;

endpackage

// ===== sv/opl_cell.sv =====
module opl_cell (
    input  logic                    i_clk,
    input  opl_pkg::t_cell_ctl      i_ctl,
    input  logic [opl_pkg::PT_W-1:0] i_key,
    input  logic [opl_pkg::PT_W-1:0] i_left,
    input  logic [opl_pkg::PT_W-1:0] i_right,
    output logic [opl_pkg::PT_W-1:0] o_data,
    output logic                    o_match
);
    import opl_pkg::*;

    logic [PT_W-1:0] r_data;
    logic [PT_W-1:0] n_data;
    logic            r_match;

    // Select the next entry: hold, load the key, or take a neighbor's entry
    always_comb begin
        unique case (i_ctl.op)
            CELL_HOLD:  n_data = r_data;
            CELL_LOAD:  n_data = i_key;
            CELL_LEFT:  n_data = i_left;
            CELL_RIGHT: n_data = i_right;
            default:    n_data = r_data;
        endcase
    end

    // Store the entry and flag a live entry equal to the key
    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= i_ctl.valid && (r_data == i_key);
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

// ===== sv/opl_scan.sv =====
`include "ordered_point_list_engine_top_macros.svh"

module opl_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [opl_pkg::CAPACITY-1:0] i_match,
    output opl_pkg::t_scan_res          o_res
);
    import opl_pkg::*;

    logic                  r_busy;
    logic [GRP_W-1:0]      r_grp;
    logic [NGRP*GRP-1:0]   w_pad;
    logic [GRP-1:0]        w_slice;
    logic                  w_hit;
    logic [GRP_IW-1:0]     w_idx;
    logic                  w_last;

    // Pad the match flags to whole groups and pick the current group
    assign w_pad   = (NGRP*GRP)'(i_match);
    assign w_slice = w_pad[r_grp*GRP +: GRP];
    assign w_last  = (r_grp == GRP_W'(NGRP - 1));

    // Find the lowest matching cell inside the group
    always_comb begin
        w_hit = 1'b0;
        w_idx = '0;
        for (int i = GRP - 1; i >= 0; i--) begin
            if (w_slice[i]) begin
                w_hit = 1'b1;
                w_idx = GRP_IW'(i);
            end
        end
    end

    always_comb begin
        o_res.done  = r_busy && (w_hit || w_last);
        o_res.found = r_busy && w_hit;
        o_res.pos   = {r_grp, w_idx};
    end

    // Advance one group a cycle until a hit or the last group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_grp  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_grp  <= '0;
        end else if (r_busy) begin
            if (w_hit || w_last) begin
                r_busy <= 1'b0;
            end else begin
                r_grp <= r_grp + 1'b1;
            end
        end
    end

    `OPL_ASSERT_IMPLY(a_start_idle, i_clk, i_rst_n, i_start, !r_busy, "scan restarted while busy")
    `OPL_ASSERT_NEXT(a_done_stops, i_clk, i_rst_n, o_res.done, !r_busy, "scan kept running after done")
    `OPL_ASSERT_IMPLY(a_pos_range, i_clk, i_rst_n, o_res.found, (POS_W+1)'(o_res.pos) < (POS_W+1)'(CAPACITY), "match position beyond list")

endmodule

// ===== sv/ordered_point_list_engine_top.sv =====
// Ordered point list engine: keeps up to CAPACITY (x,y) points in a row of cells,
// entry 0 at the head.
// Input channel: i_in_valid / o_in_stall with i_req_type, i_point_x, i_point_y.
// Request codes: push front, push back, pop front, pop back, delete first match,
// search. Each item yields exactly one result item.
// Output channel: o_out_valid / i_out_stall with popped point, found flag, match
// position, entry count after the request and status.
// Push and pop requests pass through the apply and hold states to the output register;
// delete and search first pass the match and scan states, where the scan walks k
// 8-cell groups (k from 1 to CAPACITY/8) until the first hit or the last group.
// One item is in flight at a time; the next item is taken once the result has moved
// into the output register, so no new item is accepted while one is still in work.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending result.
// While the receiver stalls, the result stays on the output ports unchanged and
// one further item may be accepted and worked up to the point of delivery.
`include "ordered_point_list_engine_top_macros.svh"

module ordered_point_list_engine_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [2:0]                  i_req_type,
    input  logic [7:0]                  i_point_x,
    input  logic [7:0]                  i_point_y,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [7:0]                  o_out_x,
    output logic [7:0]                  o_out_y,
    output logic                        o_found,
    output logic [opl_pkg::MPOS_W-1:0]  o_match_position,
    output logic [opl_pkg::OCNT_W-1:0]  o_entry_count,
    output logic [1:0]                  o_status
);
    import opl_pkg::*;

    t_state            r_state, n_state;
    logic [2:0]        r_req;
    logic [PT_W-1:0]   r_key;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_found, n_found;
    logic [POS_W-1:0]  r_pos, n_pos;
    t_result           r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    logic              w_in_acc;
    logic              w_out_free;
    logic              w_full;
    logic              w_empty;
    logic [PT_W-1:0]   w_back;
    logic [CNT_W-1:0]  w_last_idx;
    t_scan_res         w_scan;

    t_cell_ctl         w_ctl  [CAPACITY];
    logic [PT_W-1:0]   w_data [CAPACITY];
    logic [CAPACITY-1:0] w_match;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_last_idx = CNT_W'(r_count - 1'b1);

    // Row of cells; each takes its command from the request being applied
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        always_comb begin
            w_ctl[g].valid = (CNT_W'(g) < r_count);
            w_ctl[g].op    = CELL_HOLD;
            if (r_state == S_APPLY) begin
                unique case (r_req)
                    REQ_PUSH_FRONT: begin
                        if (!w_full) w_ctl[g].op = (g == 0) ? CELL_LOAD : CELL_LEFT;
                    end
                    REQ_PUSH_BACK: begin
                        if (!w_full && (r_count == CNT_W'(g))) w_ctl[g].op = CELL_LOAD;
                    end
                    REQ_POP_FRONT: begin
                        if (!w_empty) w_ctl[g].op = CELL_RIGHT;
                    end
                    REQ_DELETE: begin
                        if (r_found && (POS_W'(g) >= r_pos)) w_ctl[g].op = CELL_RIGHT;
                    end
                    default: w_ctl[g].op = CELL_HOLD;
                endcase
            end
        end

        opl_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[g]),
            .i_key   (r_key),
            .i_left  (w_data[(g == 0) ? 0 : g - 1]),
            .i_right (w_data[(g == CAPACITY - 1) ? g : g + 1]),
            .o_data  (w_data[g]),
            .o_match (w_match[g])
        );
    end

    // Group scan of the match flags for the first hit from the head
    opl_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MATCH),
        .i_match (w_match),
        .o_res   (w_scan)
    );

    // Pick the tail entry for pop back
    always_comb begin
        w_back = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (CNT_W'(i) == w_last_idx) w_back = w_back | w_data[i];
        end
    end

    // Sequence each request and build its result
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_found     = r_found;
        n_pos       = r_pos;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_found = 1'b0;
                    n_pos   = '0;
                    if ((i_req_type == REQ_DELETE) || (i_req_type == REQ_SEARCH)) begin
                        n_state = S_MATCH;
                    end else begin
                        n_state = S_APPLY;
                    end
                end
            end
            S_MATCH: n_state = S_SCAN;
            S_SCAN: begin
                if (w_scan.done) begin
                    n_found = w_scan.found;
                    n_pos   = w_scan.found ? w_scan.pos : '0;
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_res        = '0;
                n_res.status = ST_OK;
                unique case (r_req)
                    REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                        if (w_full) n_res.status = ST_FULL;
                        else        n_count = r_count + 1'b1;
                    end
                    REQ_POP_FRONT: begin
                        if (w_empty) begin
                            n_res.status = ST_EMPTY;
                        end else begin
                            {n_res.x, n_res.y} = w_data[0];
                            n_count = w_last_idx;
                        end
                    end
                    REQ_POP_BACK: begin
                        if (w_empty) begin
                            n_res.status = ST_EMPTY;
                        end else begin
                            {n_res.x, n_res.y} = w_back;
                            n_count = w_last_idx;
                        end
                    end
                    REQ_DELETE: begin
                        n_res.found = r_found;
                        n_res.pos   = MPOS_W'(r_pos);
                        if (r_found) n_count = w_last_idx;
                    end
                    REQ_SEARCH: begin
                        n_res.found = r_found;
                        n_res.pos   = MPOS_W'(r_pos);
                    end
                    default: n_res.status = ST_OK;
                endcase
                n_res.count = OCNT_W'(n_count);
                n_state     = S_HOLD;
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload: latch the request on accept, keep scan result and output
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req <= i_req_type;
            r_key <= {i_point_x, i_point_y};
        end
        r_found <= n_found;
        r_pos   <= n_pos;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_x          = r_out.x;
    assign o_out_y          = r_out.y;
    assign o_found          = r_out.found;
    assign o_match_position = r_out.pos;
    assign o_entry_count    = r_out.count;
    assign o_status         = r_out.status;

    `OPL_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY), "entry count beyond capacity")
    `OPL_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_in_acc, r_state != S_IDLE, "accepted item did not start work")
    `OPL_ASSERT_NEXT(a_hold_load, i_clk, i_rst_n, (r_state == S_HOLD) && w_out_free, o_out_valid && (o_entry_count == OCNT_W'(r_count)), "result count differs from list")

endmodule

// ===== test/testbench.sv =====
module testbench;
    import opl_pkg::*;

    // Request codes that the block ignores
    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;
    localparam int RANDOM_ITEMS = 1100;
    localparam int DRAIN_CYCLES = 20;
    localparam int PRINT_LIMIT = 100;

    typedef struct packed {
        logic [2:0] req;
        logic [7:0] x;
        logic [7:0] y;
    } list_req_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [2:0] in_req = '0;
    logic [7:0] in_x = '0;
    logic [7:0] in_y = '0;
    logic out_stall = 1'b0;

    logic o_in_stall;
    logic o_out_valid;
    logic [7:0] o_out_x;
    logic [7:0] o_out_y;
    logic o_found;
    logic [MPOS_W-1:0] o_match_position;
    logic [OCNT_W-1:0] o_entry_count;
    logic [1:0] o_status;

    // Stimulus and expectations
    list_req_t requests_todo[$];
    t_result replies_due[$];
    logic [15:0] pushed_keys[$];
    logic [15:0] key_pool[8];
    list_req_t next_item;
    t_result due;

    // Shadow copy of the list
    logic [15:0] list_pts[CAPACITY];
    int list_len = 0;

    int total_items = 0;
    int accepted_n = 0;
    int checked_n = 0;
    int err_n = 0;
    int n_full_pushes = 0;
    int n_empty_pops = 0;
    int n_hits = 0;
    int max_hit_pos = 0;
    int max_len = 0;
    bit in_fire = 1'b0;
    int send_gap = 0;
    int send_burst = 0;
    int stall_left = 0;
    int free_left = 0;

    ordered_point_list_engine_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (in_req),
        .i_point_x        (in_x),
        .i_point_y        (in_y),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_out_x          (o_out_x),
        .o_out_y          (o_out_y),
        .o_found          (o_found),
        .o_match_position (o_match_position),
        .o_entry_count    (o_entry_count),
        .o_status         (o_status)
    );

    // Apply one request to the shadow list and return the result it yields
    function automatic t_result apply_list_request(logic [2:0] req, logic [7:0] px,
                                                   logic [7:0] py);
        t_result r;
        logic [15:0] key;
        int hit;
        int drop;
        int i;
        r = '0;
        key = {px, py};
        hit = -1;
        drop = -1;
        case (req)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    if (req == REQ_PUSH_FRONT) begin
                        for (i = list_len; i > 0; i--)
                            list_pts[i] = list_pts[i-1];
                        list_pts[0] = key;
                    end else begin
                        list_pts[list_len] = key;
                    end
                    list_len++;
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (req == REQ_POP_FRONT) begin
                    {r.x, r.y} = list_pts[0];
                    drop = 0;
                end else begin
                    {r.x, r.y} = list_pts[list_len-1];
                    list_len--;
                end
            end
            REQ_DELETE, REQ_SEARCH: begin
                // First match nearest the head wins
                for (i = 0; i < list_len; i++)
                    if (hit < 0 && list_pts[i] == key)
                        hit = i;
                if (hit >= 0) begin
                    r.found = 1'b1;
                    r.pos = MPOS_W'(hit);
                    if (req == REQ_DELETE)
                        drop = hit;
                end
            end
            default: ;
        endcase
        // Close the gap left by a removed entry
        if (drop >= 0) begin
            for (i = drop; i < list_len - 1; i++)
                list_pts[i] = list_pts[i+1];
            list_len--;
        end
        r.count = OCNT_W'(list_len);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        err_n++;
        if (err_n <= PRINT_LIMIT)
            $display("mismatch at result %0d (t=%0t): %s got 0x%0h want 0x%0h",
                     checked_n, $time, what, got, want);
    endtask

    // Mostly short idles, now and then a long one
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [15:0] fresh_key();
        if ($urandom_range(0, 1) == 0)
            return key_pool[$urandom_range(0, 7)];
        return 16'($urandom);
    endfunction

    // Favor keys already pushed so that searches and deletes hit
    function automatic logic [15:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45 && pushed_keys.size() > 0)
            return pushed_keys[$urandom_range(0, pushed_keys.size() - 1)];
        if (r < 75)
            return key_pool[$urandom_range(0, 7)];
        return 16'($urandom);
    endfunction

    task automatic queue_request(logic [2:0] req, logic [15:0] key);
        list_req_t item;
        item.req = req;
        item.x = key[15:8];
        item.y = key[7:0];
        requests_todo.push_back(item);
        if (req == REQ_PUSH_FRONT || req == REQ_PUSH_BACK) begin
            pushed_keys.push_back(key);
            if (pushed_keys.size() > 96)
                pushed_keys.delete(0);
        end
    endtask

    // Build the whole request sequence up front
    initial begin : fill_requests
        int kind;
        int n;
        int r;
        logic [15:0] key;
        logic [15:0] last_back;
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        for (n = 2; n < 8; n++)
            key_pool[n] = 16'($urandom);
        last_back = 16'h0000;

        // Empty list corner cases and ignored codes
        queue_request(REQ_POP_FRONT, 16'h0000);
        queue_request(REQ_POP_BACK, 16'hFFFF);
        queue_request(REQ_SEARCH, 16'h1234);
        queue_request(REQ_DELETE, 16'h1234);
        queue_request(REQ_SPARE_A, 16'hFFFF);
        queue_request(REQ_SPARE_B, 16'hAA55);
        // Small list with a duplicate, then take it apart
        queue_request(REQ_PUSH_FRONT, 16'h0000);
        queue_request(REQ_PUSH_BACK, 16'hFFFF);
        queue_request(REQ_PUSH_FRONT, 16'h8001);
        queue_request(REQ_SEARCH, 16'hFFFF);
        queue_request(REQ_SEARCH, 16'h0000);
        queue_request(REQ_SEARCH, 16'h0180);
        queue_request(REQ_PUSH_BACK, 16'h0000);
        queue_request(REQ_DELETE, 16'h0000);
        queue_request(REQ_SEARCH, 16'h0000);
        queue_request(REQ_POP_FRONT, 16'h0000);
        queue_request(REQ_POP_BACK, 16'h0000);
        queue_request(REQ_DELETE, 16'hFFFF);
        queue_request(REQ_SEARCH, 16'hFFFF);
        // Insert into an empty list, then remove the sole entry from either end
        queue_request(REQ_PUSH_BACK, 16'h55AA);
        queue_request(REQ_POP_BACK, 16'h0000);
        queue_request(REQ_PUSH_FRONT, 16'h7FFE);
        queue_request(REQ_POP_FRONT, 16'h0000);
        queue_request(REQ_SPARE_A, 16'h0000);

        // Random phases: fill past full, drain past empty, or mixed traffic
        while (requests_todo.size() < RANDOM_ITEMS + 24) begin
            kind = $urandom_range(0, 9);
            n = 0;
            if (kind < 3) begin
                while (n < CAPACITY + 8) begin
                    if ($urandom_range(0, 99) < 85) begin
                        key = fresh_key();
                        if ($urandom_range(0, 2) == 0) begin
                            queue_request(REQ_PUSH_FRONT, key);
                        end else begin
                            queue_request(REQ_PUSH_BACK, key);
                            if (n < CAPACITY)
                                last_back = key;
                        end
                        n++;
                    end else begin
                        queue_request(REQ_SEARCH, pick_key());
                    end
                end
                queue_request(REQ_SEARCH, last_back);
                queue_request(REQ_DELETE, last_back);
            end else if (kind < 5) begin
                while (n < CAPACITY + 6) begin
                    if ($urandom_range(0, 99) < 85) begin
                        queue_request($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK,
                                      16'($urandom));
                        n++;
                    end else begin
                        queue_request($urandom_range(0, 1) ? REQ_DELETE : REQ_SEARCH,
                                      pick_key());
                    end
                end
            end else begin
                repeat ($urandom_range(20, 80)) begin
                    r = $urandom_range(0, 99);
                    if (r < 30)
                        queue_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
                                      fresh_key());
                    else if (r < 55)
                        queue_request($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK,
                                      16'($urandom));
                    else if (r < 75)
                        queue_request(REQ_DELETE, pick_key());
                    else if (r < 95)
                        queue_request(REQ_SEARCH, pick_key());
                    else
                        queue_request($urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B,
                                      16'($urandom));
                end
            end
        end
        total_items = requests_todo.size();
    end

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Drive the next item once the current one is taken, with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (send_gap > 0) begin
                in_valid <= 1'b0;
                send_gap = send_gap - 1;
            end else if (requests_todo.size() > 0) begin
                next_item = requests_todo.pop_front();
                in_valid <= 1'b1;
                in_req <= next_item.req;
                in_x <= next_item.x;
                in_y <= next_item.y;
                if (send_burst > 0) begin
                    send_burst = send_burst - 1;
                    send_gap = 0;
                end else if ($urandom_range(0, 49) == 0) begin
                    send_burst = $urandom_range(30, 80);
                    send_gap = 0;
                end else begin
                    send_gap = pick_idle();
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Stall the result side in runs, with long free stretches now and then
    always @(negedge i_clk) begin
        if (free_left > 0) begin
            out_stall <= 1'b0;
            free_left = free_left - 1;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            out_stall <= 1'b0;
            free_left = ($urandom_range(0, 29) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(0, 3);
            stall_left = pick_idle();
        end
    end

    // Predict on each accepted item, check each delivered result
    always @(posedge i_clk) begin
        in_fire = i_rst_n && in_valid && !o_in_stall;
        if (in_fire) begin
            due = apply_list_request(in_req, in_x, in_y);
            replies_due.push_back(due);
            accepted_n++;
            if (due.status == ST_FULL)
                n_full_pushes++;
            if (due.status == ST_EMPTY)
                n_empty_pops++;
            if (due.found) begin
                n_hits++;
                if (int'(due.pos) > max_hit_pos)
                    max_hit_pos = int'(due.pos);
            end
            if (list_len > max_len)
                max_len = list_len;
        end
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (replies_due.size() == 0) begin
                report_mismatch("result with none due", 8'h00, 8'h00);
            end else begin
                due = replies_due.pop_front();
                if (o_out_x !== due.x)
                    report_mismatch("out_x", o_out_x, due.x);
                if (o_out_y !== due.y)
                    report_mismatch("out_y", o_out_y, due.y);
                if (o_found !== due.found)
                    report_mismatch("found", 8'(o_found), 8'(due.found));
                if (o_match_position !== due.pos)
                    report_mismatch("match_position", 8'(o_match_position), 8'(due.pos));
                if (o_entry_count !== due.count)
                    report_mismatch("entry_count", 8'(o_entry_count), 8'(due.count));
                if (o_status !== due.status)
                    report_mismatch("status", 8'(o_status), 8'(due.status));
            end
            checked_n++;
        end
    end

    // Reset, wait for every result, then report
    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (total_items == 0 || accepted_n < total_items)
            @(posedge i_clk);
        while (replies_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d requests sent, %0d results checked, %0d mismatches",
                 accepted_n, checked_n, err_n);
        $display("%0d pushes on full, %0d pops on empty, %0d matches (deepest %0d), peak %0d",
                 n_full_pushes, n_empty_pops, n_hits, max_hit_pos, max_len);
        if (err_n == 0)
            $display("ordered_point_list_engine_top regression: pass");
        else
            $display("ordered_point_list_engine_top regression: fail");
        $finish;
    end

    // Hard stop if the block hangs
    initial begin
        #2000000;
        $display("timeout: %0d of %0d items accepted, %0d results due",
                 accepted_n, total_items, replies_due.size());
        $display("ordered_point_list_engine_top regression: fail");
        $finish;
    end

endmodule
